[rtl/ghtq_pkg.sv]
package ghtq_pkg;

	localparam int NUM_TIMERS = 64;
	localparam int ID_BITS    = 6;
	localparam int TIME_BITS  = 48;
	localparam int DUR_BITS   = 32;
	localparam int SEQ_BITS   = 32;
	localparam int CNT_BITS   = 7;

	typedef enum logic [1:0] {
		KIND_ARM    = 2'd0,
		KIND_CANCEL = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_STOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		EV_ACK       = 2'd0,
		EV_EXPIRED   = 2'd1,
		EV_STOPPED   = 2'd2,
		EV_IDLE_TICK = 2'd3
	} ev_t;

	typedef struct packed {
		kind_t                kind;
		logic [ID_BITS-1:0]   timer_id;
		logic [DUR_BITS-1:0]  duration;
	} req_t;

	typedef struct packed {
		ev_t                  event_res;
		logic [ID_BITS-1:0]   timer_id_res;
		logic [TIME_BITS-1:0] due_ms;
		logic                 last;
		logic [CNT_BITS-1:0]  pending;
	} res_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] deadline;
		logic [DUR_BITS-1:0]  duration;
		logic [SEQ_BITS-1:0]  seq;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ACK,
		ST_SCAN,
		ST_SCAN_END,
		ST_RESOLVE
	} state_t;

	typedef struct packed {
		logic accept;
		logic ack;
		logic tick_adv;
		logic scan_clear;
		logic held_clear;
		logic scan_step;
		logic take;
		logic finish;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  out_free;
		logic  scan_last;
		logic  found;
		logic  held;
	} status_t;

endpackage

[rtl/ghtq_ram.sv]
module ghtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ghtq_ctrl.sv]
module ghtq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  ghtq_pkg::status_t sts,
	output logic              req_stall,
	output ghtq_pkg::cmd_t    cmd
);

	ghtq_pkg::state_t state_q, state_d;
	logic             is_rw;

	assign is_rw     = (sts.kind == ghtq_pkg::KIND_ARM) || (sts.kind == ghtq_pkg::KIND_CANCEL);
	assign req_stall = (state_q != ghtq_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghtq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ghtq_pkg::ST_IDLE: begin
				if (req_valid) state_d = ghtq_pkg::ST_DECODE;
			end
			ghtq_pkg::ST_DECODE: begin
				state_d = is_rw ? ghtq_pkg::ST_ACK : ghtq_pkg::ST_SCAN;
			end
			ghtq_pkg::ST_ACK: begin
				if (sts.out_free) state_d = ghtq_pkg::ST_IDLE;
			end
			ghtq_pkg::ST_SCAN: begin
				if (sts.scan_last) state_d = ghtq_pkg::ST_SCAN_END;
			end
			ghtq_pkg::ST_SCAN_END: begin
				state_d = ghtq_pkg::ST_RESOLVE;
			end
			ghtq_pkg::ST_RESOLVE: begin
				if (sts.found) begin
					if (!sts.held || sts.out_free) state_d = ghtq_pkg::ST_SCAN;
				end else if (sts.out_free) begin
					state_d = ghtq_pkg::ST_IDLE;
				end
			end
			default: state_d = ghtq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ghtq_pkg::ST_IDLE: begin
				cmd.accept = req_valid;
			end
			ghtq_pkg::ST_DECODE: begin
				cmd.tick_adv   = (sts.kind == ghtq_pkg::KIND_TICK);
				cmd.scan_clear = !is_rw;
				cmd.held_clear = !is_rw;
			end
			ghtq_pkg::ST_ACK: begin
				cmd.ack = sts.out_free;
			end
			ghtq_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ghtq_pkg::ST_SCAN_END: begin
			end
			ghtq_pkg::ST_RESOLVE: begin
				if (sts.found) begin
					cmd.take       = !sts.held || sts.out_free;
					cmd.scan_clear = !sts.held || sts.out_free;
				end else begin
					cmd.finish = sts.out_free;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/ghtq_dp.sv]
module ghtq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ghtq_pkg::req_t     req,
	input  logic               res_stall,
	input  ghtq_pkg::cmd_t     cmd,
	output ghtq_pkg::status_t  sts,
	output logic               res_valid,
	output ghtq_pkg::res_t     res
);

	ghtq_pkg::req_t                        req_q;
	logic [ghtq_pkg::TIME_BITS-1:0]        now_q;
	logic [ghtq_pkg::NUM_TIMERS-1:0]       armed_q;
	logic [ghtq_pkg::CNT_BITS-1:0]         cnt_q;
	logic [ghtq_pkg::SEQ_BITS-1:0]         seq_q;
	logic [ghtq_pkg::ID_BITS-1:0]          scan_q;
	logic                                  cmp_v_s1;
	logic [ghtq_pkg::ID_BITS-1:0]          idx_s1;
	logic                                  found_q;
	ghtq_pkg::entry_t                      best_q;
	logic [ghtq_pkg::ID_BITS-1:0]          best_id_q;
	logic                                  held_q;
	ghtq_pkg::res_t                        held_res_q;
	ghtq_pkg::res_t                        res_q;
	logic                                  res_valid_q;

	logic                                  we;
	logic [ghtq_pkg::ID_BITS-1:0]          raddr;
	ghtq_pkg::entry_t                      wentry;
	ghtq_pkg::entry_t                      rentry;
	logic [ghtq_pkg::ENTRY_BITS-1:0]       rdata;
	logic [ghtq_pkg::TIME_BITS-1:0]        new_dl;
	logic                                  is_tick;
	logic                                  id_armed;
	logic                                  cand;
	logic                                  better;
	logic                                  out_free;
	ghtq_pkg::res_t                        ack_res;
	ghtq_pkg::res_t                        fin_res;

	assign is_tick  = (req_q.kind == ghtq_pkg::KIND_TICK);
	assign id_armed = armed_q[req_q.timer_id];
	assign new_dl   = now_q + ghtq_pkg::TIME_BITS'(req_q.duration);
	assign we       = cmd.ack && (req_q.kind == ghtq_pkg::KIND_ARM);
	assign raddr    = cmd.scan_step ? scan_q : req_q.timer_id;
	assign rentry   = ghtq_pkg::entry_t'(rdata);
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		wentry          = '0;
		wentry.deadline = new_dl;
		wentry.duration = req_q.duration;
		wentry.seq      = seq_q;
	end

	ghtq_ram #(
		.WIDTH(ghtq_pkg::ENTRY_BITS),
		.DEPTH(ghtq_pkg::NUM_TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(req_q.timer_id),
		.wdata(wentry),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		cand = cmp_v_s1 && armed_q[idx_s1] && (!is_tick || (rentry.deadline <= now_q));
		if (is_tick) begin
			better = {rentry.deadline, rentry.duration, rentry.seq} <
				{best_q.deadline, best_q.duration, best_q.seq};
		end else begin
			better = (rentry.duration < best_q.duration) ||
				((rentry.duration == best_q.duration) && (rentry.seq > best_q.seq));
		end
	end

	always_comb begin
		ack_res              = '0;
		ack_res.event_res    = ghtq_pkg::EV_ACK;
		ack_res.timer_id_res = req_q.timer_id;
		ack_res.last         = 1'b1;
		if (req_q.kind == ghtq_pkg::KIND_ARM) begin
			ack_res.due_ms  = new_dl;
			ack_res.pending = id_armed ? cnt_q : cnt_q + ghtq_pkg::CNT_BITS'(1);
		end else begin
			ack_res.due_ms  = id_armed ? rentry.deadline : '0;
			ack_res.pending = id_armed ? cnt_q - ghtq_pkg::CNT_BITS'(1) : cnt_q;
		end
	end

	always_comb begin
		fin_res      = '0;
		fin_res.last = 1'b1;
		if (held_q) begin
			fin_res      = held_res_q;
			fin_res.last = 1'b1;
		end else if (is_tick) begin
			fin_res.event_res = ghtq_pkg::EV_IDLE_TICK;
			fin_res.due_ms    = now_q;
			fin_res.pending   = cnt_q;
		end else begin
			fin_res.event_res = ghtq_pkg::EV_ACK;
			fin_res.pending   = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			armed_q     <= '0;
			cnt_q       <= '0;
			seq_q       <= '0;
			scan_q      <= '0;
			cmp_v_s1    <= 1'b0;
			found_q     <= 1'b0;
			held_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			cmp_v_s1 <= cmd.scan_step;
			if (cmd.tick_adv) now_q <= now_q + ghtq_pkg::TIME_BITS'(1);
			if (cmd.scan_step) scan_q <= scan_q + ghtq_pkg::ID_BITS'(1);
			if (cmd.scan_clear) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (cand && (!found_q || better)) begin
				found_q <= 1'b1;
			end
			if (cmd.held_clear) held_q <= 1'b0;
			if (cmd.take) held_q <= 1'b1;
			if (cmd.ack) begin
				if (req_q.kind == ghtq_pkg::KIND_ARM) begin
					armed_q[req_q.timer_id] <= 1'b1;
					seq_q                   <= seq_q + ghtq_pkg::SEQ_BITS'(1);
				end else begin
					armed_q[req_q.timer_id] <= 1'b0;
				end
				cnt_q <= ack_res.pending;
			end
			if (cmd.take) begin
				armed_q[best_id_q] <= 1'b0;
				cnt_q              <= cnt_q - ghtq_pkg::CNT_BITS'(1);
			end
			if (cmd.ack || cmd.finish || (cmd.take && held_q)) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= req;
		idx_s1 <= scan_q;
		if (!cmd.scan_clear && cand && (!found_q || better)) begin
			best_q    <= rentry;
			best_id_q <= idx_s1;
		end
		if (cmd.take) begin
			held_res_q.event_res    <= is_tick ? ghtq_pkg::EV_EXPIRED : ghtq_pkg::EV_STOPPED;
			held_res_q.timer_id_res <= best_id_q;
			held_res_q.due_ms       <= best_q.deadline;
			held_res_q.last         <= 1'b0;
			held_res_q.pending      <= cnt_q - ghtq_pkg::CNT_BITS'(1);
		end
		if (cmd.ack) begin
			res_q <= ack_res;
		end else if (cmd.finish) begin
			res_q <= fin_res;
		end else if (cmd.take && held_q) begin
			res_q <= held_res_q;
		end
	end

	always_comb begin
		sts           = '0;
		sts.kind      = req_q.kind;
		sts.out_free  = out_free;
		sts.scan_last = (scan_q == ghtq_pkg::ID_BITS'(ghtq_pkg::NUM_TIMERS - 1));
		sts.found     = found_q;
		sts.held      = held_q;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/grouped_heap_timeout_queue_top.sv]
// Channel | Direction | Handshake          | Word
// req     | in        | req_valid/req_stall | ghtq_pkg::req_t
// res     | out       | res_valid/res_stall | ghtq_pkg::res_t
//
// Arm and cancel pass through accept, decode and acknowledge states; the acknowledge waits for the output register.
// Tick and stop-all pass through accept and decode states, then scan the 64-entry
// timer memory one entry per cycle: one full scan per reported timer plus one more
// scan that finds nothing.
// Reset clears the clock, the armed bits and the count; memory needs no clearing.
// A full output register stalls the block before it loads the next word.
module grouped_heap_timeout_queue_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ghtq_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output ghtq_pkg::res_t res
);

	ghtq_pkg::cmd_t    cmd;
	ghtq_pkg::status_t sts;

	ghtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.sts      (sts),
		.req_stall(req_stall),
		.cmd      (cmd)
	);

	ghtq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res_stall(res_stall),
		.cmd      (cmd),
		.sts      (sts),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule
